// ----- sv/source_text_lexer_defines.svh -----
// Assertion macros for the lexer RTL; included by stl_res_fifo.
// No dependencies; include by bare file name.
`ifndef SOURCE_TEXT_LEXER_DEFINES_SVH
`define SOURCE_TEXT_LEXER_DEFINES_SVH

// same-cycle implication
`define STL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// next-cycle implication
`define STL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

// ----- sv/stl_pkg.sv -----
// Shared types, token codes and saturating helpers for the source text lexer.
// No dependencies.
`default_nettype none
package stl_pkg;

    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 16;
    localparam int OFFSET_BITS = 24;
    localparam int VALUE_BITS  = 63;

    localparam logic [5:0] K_IDENT  = 6'd0;
    localparam logic [5:0] K_STRING = 6'd1;
    localparam logic [5:0] K_INT    = 6'd2;
    localparam logic [5:0] K_FN     = 6'd3;
    localparam logic [5:0] K_LET    = 6'd4;
    localparam logic [5:0] K_IF     = 6'd5;
    localparam logic [5:0] K_SLASH  = 6'd6;
    localparam logic [5:0] K_END    = 6'd36;

    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_UNKNOWN = 2'd1;
    localparam logic [1:0] E_UNTERM  = 2'd2;

    typedef struct packed {
        logic [5:0]             kind;
        logic [LINE_BITS-1:0]   sl;
        logic [COLUMN_BITS-1:0] sc;
        logic [LINE_BITS-1:0]   el;
        logic [COLUMN_BITS-1:0] ec;
        logic [OFFSET_BITS-1:0] off;
        logic [OFFSET_BITS-1:0] len;
        logic [VALUE_BITS-1:0]  val;
        logic [1:0]             err;
        logic [7:0]             bad;
        logic                   last;
    } t_result;

    function automatic logic [LINE_BITS-1:0] sat_line(input logic [LINE_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [COLUMN_BITS-1:0] sat_col(input logic [COLUMN_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage
`default_nettype wire

// ----- sv/stl_res_fifo.sv -----
// Four-entry result queue; takes up to two results per cycle, gives one per cycle on pop.
// Depends on stl_pkg and source_text_lexer_defines.svh.
`default_nettype none
`include "source_text_lexer_defines.svh"
module stl_res_fifo
    import stl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic [1:0] i_push_cnt,
    input  wire t_result i_wd0,
    input  wire t_result i_wd1,
    input  wire logic    i_pop,
    output logic         o_valid,
    output t_result      o_head,
    output logic         o_room2
);
    t_result    r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [1:0] n_wp, n_rp;
    logic [2:0] n_cnt;
    logic       pop_ok;

    assign o_valid = (r_cnt != 3'd0);
    assign o_head  = r_mem[r_rp];
    assign o_room2 = (r_cnt <= 3'd2);
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp + i_push_cnt;
        n_rp  = r_rp + {1'b0, pop_ok};
        n_cnt = r_cnt + {1'b0, i_push_cnt} - {2'b0, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) r_mem[r_wp] <= i_wd0;
        if (i_push_cnt == 2'd2) r_mem[r_wp + 2'd1] <= i_wd1;
    end

    `STL_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= 3'd4)
    `STL_ASSERT_IMP(a_no_over, i_clk, i_rst_n, i_push_cnt != 2'd0, r_cnt <= 3'd2)
    `STL_ASSERT_IMP(a_push_cnt, i_clk, i_rst_n, 1'b1, i_push_cnt != 2'd3)
    `STL_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_pop, o_valid)
endmodule
`default_nettype wire

// ----- sv/source_text_lexer.sv -----
// Source text lexer top level: per-byte scan logic feeding the result queue.
// Depends on stl_pkg and stl_res_fifo.
//
// channel | dir | fields
// s_axis  | in  | tdata[7:0] char_byte
// m_axis  | out | tdata: positions, offset, length, value, bad char; tuser: kind, error
//
// One byte per cycle while ready is high; each byte is scanned in the cycle it is taken.
// A byte yields up to two words; a four-entry queue drains one per cycle while output
// ready is high, so sustained rate is one byte per cycle if no byte gives two words.
// Input ready drops while the queue holds more than two words.
// Reset is synchronous, active low; no clearing pass.
`default_nettype none
module source_text_lexer
    import stl_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [7:0]   i_s_tdata,   // [7:0] char_byte
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // [15:0] first_line, [31:16] start_column, [47:32] end_line, [63:48] end_column,
    // [87:64] text_offset, [111:88] text_length, [174:112] int_value,
    // [182:175] bad_char, [183] zero
    output logic [183:0]      o_m_tdata,
    output logic [7:0]        o_m_tuser,   // [5:0] token_kind, [7:6] error_code
    output logic              o_m_tlast
);
    localparam logic [3:0] M_IDLE = 4'd0;
    localparam logic [3:0] M_IDENT = 4'd1;
    localparam logic [3:0] M_ZERO = 4'd2;
    localparam logic [3:0] M_NUM = 4'd3;
    localparam logic [3:0] M_STR = 4'd4;
    localparam logic [3:0] M_OP = 4'd5;
    localparam logic [3:0] M_LCOM = 4'd6;
    localparam logic [3:0] M_BCOM = 4'd7;
    localparam logic [3:0] M_ERR = 4'd8;

    localparam logic [VALUE_BITS-1:0] MAX_VAL = '1;
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

    logic [3:0]             r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_pos, n_pos, r_tso, n_tso, r_len, n_len;
    logic [LINE_BITS-1:0]   r_line, n_line, r_tsl, n_tsl;
    logic [COLUMN_BITS-1:0] r_col, n_col, r_tsc, n_tsc;
    logic [VALUE_BITS-1:0]  r_val, n_val;
    logic [2:0]             r_base, n_base, r_kw, n_kw;
    logic                   r_froz, n_froz, r_star, n_star;
    logic [7:0]             r_pend, n_pend;

    logic       acc, room2, fresh, str_err, end_rst, e0v, e1v;
    logic       is_dig, is_alp, is_sp;
    logic [7:0] c;
    logic [5:0] wcode, pcode, pend_code;
    logic       wide_ok, plain_ok;
    logic [3:0] dig;
    logic [VALUE_BITS+5:0] prod, dsum;
    logic [VALUE_BITS-1:0] dig_val;
    logic       dig_bad;
    t_result    e0, e1, wd0, wd1, head;
    logic [1:0] push_cnt;

    function automatic t_result mk(input logic [5:0] kind,
                                   input logic [LINE_BITS-1:0] sl,
                                   input logic [COLUMN_BITS-1:0] sc,
                                   input logic [LINE_BITS-1:0] el,
                                   input logic [COLUMN_BITS-1:0] ec,
                                   input logic [OFFSET_BITS-1:0] off,
                                   input logic [OFFSET_BITS-1:0] len,
                                   input logic [VALUE_BITS-1:0] val,
                                   input logic [1:0] err,
                                   input logic [7:0] bad);
        t_result r;
        r.kind = kind; r.sl = sl; r.sc = sc; r.el = el; r.ec = ec;
        r.off = off; r.len = len; r.val = val; r.err = err; r.bad = bad;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic logic [2:0] kw_next(input logic [2:0] k, input logic [7:0] ch);
        case (k)
            3'd1: kw_next = (ch == "n") ? 3'd2 : 3'd0;
            3'd3: kw_next = (ch == "e") ? 3'd4 : 3'd0;
            3'd4: kw_next = (ch == "t") ? 3'd5 : 3'd0;
            3'd6: kw_next = (ch == "f") ? 3'd7 : 3'd0;
            default: kw_next = 3'd0;
        endcase
    endfunction

    function automatic logic [5:0] wide_of(input logic [7:0] ch);
        case (ch)
            "/": wide_of = 6'd6;
            "+": wide_of = 6'd8;
            "-": wide_of = 6'd10;
            "*": wide_of = 6'd12;
            "%": wide_of = 6'd14;
            "=": wide_of = 6'd16;
            ">": wide_of = 6'd18;
            "<": wide_of = 6'd20;
            "&": wide_of = 6'd22;
            "|": wide_of = 6'd24;
            default: wide_of = 6'd63;
        endcase
    endfunction

    function automatic logic [5:0] plain_of(input logic [7:0] ch);
        case (ch)
            ".": plain_of = 6'd26;
            ",": plain_of = 6'd27;
            ":": plain_of = 6'd28;
            ";": plain_of = 6'd29;
            "(": plain_of = 6'd30;
            ")": plain_of = 6'd31;
            "{": plain_of = 6'd32;
            "}": plain_of = 6'd33;
            "[": plain_of = 6'd34;
            "]": plain_of = 6'd35;
            default: plain_of = 6'd63;
        endcase
    endfunction

    assign acc = i_s_tvalid && o_s_tready;
    assign o_s_tready = room2;
    assign c = i_s_tdata;

    always_comb begin
        is_dig   = (c inside {["0":"9"]});
        is_alp   = (c inside {["a":"z"], ["A":"Z"]});
        is_sp    = (c == " ") || (c inside {[8'd9:8'd13]});
        wcode    = wide_of(c);
        pcode    = plain_of(c);
        wide_ok  = (wcode != 6'd63);
        plain_ok = (pcode != 6'd63);
        pend_code = wide_of(r_pend);
        if (pend_code == 6'd63) pend_code = K_SLASH;
        dig = c[3:0];
        case (r_base)
            3'd1: prod = {6'b0, r_val} << 1;
            3'd2: prod = {6'b0, r_val} << 3;
            3'd3: prod = {6'b0, r_val} << 4;
            3'd4: prod = {6'b0, r_val} << 5;
            default: prod = ({6'b0, r_val} << 3) + ({6'b0, r_val} << 1);
        endcase
        dsum = prod + {{(VALUE_BITS+2){1'b0}}, dig};
        dig_val = (dsum > {6'b0, MAX_VAL}) ? MAX_VAL : dsum[VALUE_BITS-1:0];
        case (r_base)
            3'd1: dig_bad = (dig >= 4'd2);
            3'd2: dig_bad = (dig >= 4'd8);
            default: dig_bad = 1'b0;
        endcase
    end

    always_comb begin
        n_mode = r_mode; n_pos = r_pos; n_line = r_line; n_col = r_col;
        n_tsl = r_tsl; n_tsc = r_tsc; n_tso = r_tso; n_len = r_len;
        n_val = r_val; n_base = r_base; n_froz = r_froz; n_kw = r_kw;
        n_pend = r_pend; n_star = r_star;
        e0v = 1'b0; e1v = 1'b0; e0 = '0; e1 = '0;
        fresh = 1'b0; str_err = 1'b0; end_rst = 1'b0;

        case (r_mode)
            M_IDENT: begin
                if (is_alp || is_dig) begin
                    n_len = sat_off(r_len);
                    n_kw  = kw_next(r_kw, c);
                end else begin
                    e0v = 1'b1;
                    e0 = mk((r_kw == 3'd2) ? K_FN : (r_kw == 3'd5) ? K_LET :
                            (r_kw == 3'd7) ? K_IF : K_IDENT,
                            r_tsl, r_tsc, r_line, r_col, r_tso, r_len, '0, E_NONE, 8'd0);
                    fresh = 1'b1;
                end
            end
            M_ZERO, M_NUM: begin
                if (r_mode == M_ZERO && (c == "b" || c == "d" || c == "o" ||
                                         c == "x" || c == "z")) begin
                    n_base = (c == "b") ? 3'd1 : (c == "o") ? 3'd2 :
                             (c == "x") ? 3'd3 : (c == "z") ? 3'd4 : 3'd0;
                    n_mode = M_NUM;
                end else if (is_dig) begin
                    if (!r_froz) begin
                        if (dig_bad) n_froz = 1'b1;
                        else n_val = dig_val;
                    end
                    n_mode = M_NUM;
                end else begin
                    e0v = 1'b1;
                    e0 = mk(K_INT, r_tsl, r_tsc, r_line, r_col, '0, '0, r_val,
                            E_NONE, 8'd0);
                    fresh = 1'b1;
                end
            end
            M_STR: begin
                if (c == 8'd0) begin
                    e0v = 1'b1;
                    e0 = mk(K_END, r_tsl, r_tsc, r_line, r_col, '0, '0, '0,
                            E_UNTERM, 8'd0);
                    n_mode = M_ERR;
                    str_err = 1'b1;
                end else if (c == "\"") begin
                    e0v = 1'b1;
                    e0 = mk(K_STRING, r_tsl, r_tsc, r_line, sat_col(r_col), r_tso, r_len,
                            '0, E_NONE, 8'd0);
                    n_mode = M_IDLE;
                end else begin
                    n_len = sat_off(r_len);
                end
            end
            M_OP: begin
                if (c == ((r_pend == "&") ? 8'h26 : (r_pend == "|") ? 8'h7c : 8'h3d)) begin
                    e0v = 1'b1;
                    e0 = mk(pend_code + 6'd1, r_tsl, r_tsc, r_tsl, sat_col(r_tsc),
                            '0, '0, '0, E_NONE, 8'd0);
                    n_mode = M_IDLE;
                end else if (r_pend == "/" && c == "/") begin
                    n_mode = M_LCOM;
                end else if (r_pend == "/" && c == "*") begin
                    n_mode = M_BCOM;
                    n_star = 1'b0;
                end else begin
                    e0v = 1'b1;
                    e0 = mk(pend_code, r_tsl, r_tsc, r_tsl, r_tsc, '0, '0, '0,
                            E_NONE, 8'd0);
                    fresh = 1'b1;
                end
            end
            M_LCOM: begin
                if (c == 8'h0a) n_mode = M_IDLE;
                else if (c == 8'd0) fresh = 1'b1;
            end
            M_BCOM: begin
                if (c == 8'd0) fresh = 1'b1;
                else if (r_star && c == "/") n_mode = M_IDLE;
                else n_star = (c == "*");
            end
            M_ERR: begin
            end
            default: fresh = 1'b1;
        endcase

        if (fresh) begin
            n_mode = M_IDLE;
            if (c == 8'd0) begin
                e1v = 1'b1;
                e1 = mk(K_END, r_line, r_col, r_line, r_col, '0, '0, '0, E_NONE, 8'd0);
                end_rst = 1'b1;
            end else if (is_sp) begin
            end else if (is_alp) begin
                n_tsl = r_line; n_tsc = r_col; n_tso = r_pos;
                n_len = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
                n_kw = (c == "f") ? 3'd1 : (c == "l") ? 3'd3 : (c == "i") ? 3'd6 : 3'd0;
                n_mode = M_IDENT;
            end else if (is_dig) begin
                n_tsl = r_line; n_tsc = r_col; n_tso = r_pos;
                n_val = {{(VALUE_BITS-4){1'b0}}, dig};
                n_base = 3'd0; n_froz = 1'b0;
                n_mode = (c == "0") ? M_ZERO : M_NUM;
            end else if (c == "\"") begin
                n_tsl = r_line; n_tsc = r_col; n_tso = sat_off(r_pos);
                n_len = '0;
                n_mode = M_STR;
            end else if (wide_ok) begin
                n_tsl = r_line; n_tsc = r_col; n_tso = r_pos;
                n_pend = c;
                n_mode = M_OP;
            end else if (plain_ok) begin
                e1v = 1'b1;
                e1 = mk(pcode, r_line, r_col, r_line, r_col, '0, '0, '0, E_NONE, 8'd0);
            end else begin
                e1v = 1'b1;
                e1 = mk(K_END, r_line, r_col, r_line, r_col, '0, '0, '0, E_UNKNOWN, c);
                n_mode = M_ERR;
            end
        end

        if (end_rst) begin
            n_mode = M_IDLE; n_pos = '0; n_line = LINE_ONE; n_col = COL_ONE;
            n_tsl = LINE_ONE; n_tsc = COL_ONE; n_tso = '0; n_len = '0; n_val = '0;
            n_base = 3'd0; n_froz = 1'b0; n_kw = 3'd0; n_pend = 8'd0; n_star = 1'b0;
        end else if (!str_err && r_mode != M_ERR) begin
            if (c == 8'h0a) begin
                n_line = sat_line(r_line);
                n_col  = COL_ONE;
            end else begin
                n_col = sat_col(r_col);
            end
            n_pos = sat_off(r_pos);
        end

        if (e1v) e1.last = 1'b1;
        else e0.last = 1'b1;
    end

    always_comb begin
        wd0 = e0v ? e0 : e1;
        wd1 = e1;
        push_cnt = acc ? ({1'b0, e0v} + {1'b0, e1v}) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_pos <= '0; r_line <= LINE_ONE; r_col <= COL_ONE;
            r_tsl <= LINE_ONE; r_tsc <= COL_ONE; r_tso <= '0; r_len <= '0; r_val <= '0;
            r_base <= 3'd0; r_froz <= 1'b0; r_kw <= 3'd0; r_pend <= 8'd0; r_star <= 1'b0;
        end else if (acc) begin
            r_mode <= n_mode; r_pos <= n_pos; r_line <= n_line; r_col <= n_col;
            r_tsl <= n_tsl; r_tsc <= n_tsc; r_tso <= n_tso; r_len <= n_len;
            r_val <= n_val; r_base <= n_base; r_froz <= n_froz; r_kw <= n_kw;
            r_pend <= n_pend; r_star <= n_star;
        end
    end

    stl_res_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_wd0      (wd0),
        .i_wd1      (wd1),
        .i_pop      (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_head     (head),
        .o_room2    (room2)
    );

    assign o_m_tdata = {1'b0, head.bad, head.val, head.len, head.off,
                        head.ec, head.el, head.sc, head.sl};
    assign o_m_tuser = {head.err, head.kind};
    assign o_m_tlast = head.last;
endmodule
`default_nettype wire
